FILE: rtl/core/sps_pkg.sv
// Shared types, codes and constants for the slotted page store.
// Used by the controller, the datapath and the top level; depends on nothing.
package sps_pkg;

  // Default page geometry.
  localparam int PAGE_BYTES_DEF   = 4096;
  localparam int HEADER_BYTES_DEF = 16;
  localparam int SLOT_ENTRY_BYTES = 4;

  // Field widths of the item formats.
  localparam int OP_W     = 2;
  localparam int LEN_W    = 12;
  localparam int BYTE_W   = 8;
  localparam int SLOT_W   = 10;
  localparam int IDX_W    = 12;
  localparam int STATUS_W = 3;
  localparam int CNT_W    = 11;   // slot counter, one bit wider than a slot number
  localparam int PEND_W   = 12;
  localparam int HALF_W   = 16;   // one slot entry half (offset or length)

  // Operation codes.
  localparam logic [OP_W-1:0] OP_INIT    = 2'd0;
  localparam logic [OP_W-1:0] OP_INSERT  = 2'd1;
  localparam logic [OP_W-1:0] OP_RECBYTE = 2'd2;
  localparam logic [OP_W-1:0] OP_READ    = 2'd3;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NO_SPACE = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_SLOT = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_IDX  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NO_OPEN  = 3'd4;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_WR_ENT,
    S_RD_ENT,
    S_RD_LAST,
    S_CHK,
    S_REC_WAIT,
    S_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                load_in;
    logic                ent_ld;
    logic                init;
    logic                ins_commit;
    logic                byte_wr;
    logic                ent_wr;
    logic                ent_rd;
    logic                rec_rd;
    logic                cap_ent;
    logic                cap_rec;
    logic                slen_ld;
    logic                cnt_clr;
    logic                cnt_inc;
    logic                set_status;
    logic [STATUS_W-1:0] status;
    logic                out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            fits;
    logic            pend_zero;
    logic            slot_bad;
    logic            idx_bad;
    logic            cnt_zero;
    logic            cnt_last;
    logic            out_free;
  } stat_t;

endpackage

FILE: rtl/core/sps_ram.sv
// Generic single-port RAM with a registered read port.
// Self-contained; used for the page memory of the slotted page store.
module sps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One access per cycle: a write, or a read whose data appears next cycle.
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

FILE: rtl/core/sps_ctrl.sv
// Controller state machine of the slotted page store.
// Depends on sps_pkg; drives the datapath through cmd_t and reads stat_t.
module sps_ctrl
  import sps_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.ent_ld = 1'b1;
        case (stat.op)
          OP_INIT: begin
            cmd.init  = 1'b1;
            state_nxt = S_DONE;
          end
          OP_INSERT: begin
            if (stat.fits) begin
              cmd.ins_commit = 1'b1;
              cmd.cnt_clr    = 1'b1;
              state_nxt      = S_WR_ENT;
            end else begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_NO_SPACE;
              state_nxt      = S_DONE;
            end
          end
          OP_RECBYTE: begin
            if (stat.pend_zero) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_NO_OPEN;
            end else begin
              cmd.byte_wr = 1'b1;
            end
            state_nxt = S_DONE;
          end
          OP_READ: begin
            if (stat.slot_bad) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_BAD_SLOT;
              state_nxt      = S_DONE;
            end else begin
              cmd.cnt_clr = 1'b1;
              state_nxt   = S_RD_ENT;
            end
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end
      S_WR_ENT: begin
        // Four entry bytes: offset low, offset high, length low, length high.
        cmd.ent_wr  = 1'b1;
        cmd.cnt_inc = 1'b1;
        if (stat.cnt_last) begin
          state_nxt = S_DONE;
        end
      end
      S_RD_ENT: begin
        // Each cycle issues one entry read and, after the first, captures the previous one.
        cmd.ent_rd  = 1'b1;
        cmd.cnt_inc = 1'b1;
        cmd.cap_ent = !stat.cnt_zero;
        if (stat.cnt_last) begin
          state_nxt = S_RD_LAST;
        end
      end
      S_RD_LAST: begin
        cmd.cap_ent = 1'b1;
        state_nxt   = S_CHK;
      end
      S_CHK: begin
        cmd.slen_ld = 1'b1;
        if (stat.idx_bad) begin
          cmd.set_status = 1'b1;
          cmd.status     = ST_BAD_IDX;
          state_nxt      = S_DONE;
        end else begin
          cmd.rec_rd = 1'b1;
          state_nxt  = S_REC_WAIT;
        end
      end
      S_REC_WAIT: begin
        cmd.cap_rec = 1'b1;
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        // Hand the result over once the output register is free.
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/core/sps_dp.sv
// Datapath of the slotted page store: page pointers, page memory, result register.
// Depends on sps_pkg and sps_ram; controlled by sps_ctrl through cmd_t.
module sps_dp
  import sps_pkg::*;
#(
  parameter int PAGE_BYTES   = PAGE_BYTES_DEF,
  parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cmd_t                cmd,
  output stat_t               stat,
  // Input item fields
  input  logic [OP_W-1:0]     in_operation,
  input  logic [LEN_W-1:0]    in_record_length,
  input  logic [BYTE_W-1:0]   in_data_byte,
  input  logic [SLOT_W-1:0]   in_slot_number,
  input  logic [IDX_W-1:0]    in_byte_index,
  // Result item
  input  logic                out_ready,
  output logic                out_valid,
  output logic [STATUS_W-1:0] out_status,
  output logic [SLOT_W-1:0]   out_assigned_slot,
  output logic [BYTE_W-1:0]   out_read_data,
  output logic [LEN_W-1:0]    out_stored_length,
  output logic                out_insert_done,
  output logic [LEN_W-1:0]    out_free_bytes,
  output logic [SLOT_W-1:0]   out_slots_used
);

  localparam int ADDR_W = $clog2(PAGE_BYTES);
  localparam int PTR_W  = $clog2(PAGE_BYTES + 1);
  localparam int CMP_W  = ((PTR_W > LEN_W) ? PTR_W : LEN_W) + 1;

  // Latched input item.
  logic [OP_W-1:0]   op_r;
  logic [LEN_W-1:0]  len_r;
  logic [BYTE_W-1:0] data_r;
  logic [SLOT_W-1:0] slot_r;
  logic [IDX_W-1:0]  idx_r;

  // Page state.
  logic [CNT_W-1:0]  slot_total_r, slot_total_nxt;
  logic [PTR_W-1:0]  dir_end_r, dir_end_nxt;
  logic [PTR_W-1:0]  ras_r, ras_nxt;
  logic [PTR_W-1:0]  fill_r, fill_nxt;
  logic [PEND_W-1:0] pend_r, pend_nxt;

  // Entry access.
  logic [ADDR_W-1:0] ent_base_r;
  logic [1:0]        cnt_r, cnt_nxt;
  logic [HALF_W-1:0] off_r;
  logic [HALF_W-1:0] rlen_r;

  // Result under construction.
  logic [STATUS_W-1:0] res_status_r;
  logic [SLOT_W-1:0]   res_assigned_r;
  logic [BYTE_W-1:0]   res_rdata_r;
  logic [LEN_W-1:0]    res_slen_r;
  logic                res_done_r;

  // Output register.
  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r;
  logic [SLOT_W-1:0]   out_assigned_r;
  logic [BYTE_W-1:0]   out_rdata_r;
  logic [LEN_W-1:0]    out_slen_r;
  logic                out_done_r;
  logic [LEN_W-1:0]    out_free_r;
  logic [SLOT_W-1:0]   out_slots_r;

  // Memory port.
  logic              ram_en;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_addr;
  logic [BYTE_W-1:0] ram_wdata;
  logic [BYTE_W-1:0] ram_rdata;

  // Derived values.
  logic [PTR_W-1:0]  space_left;
  logic [PTR_W-1:0]  rec_start;
  logic [CNT_W-1:0]  sel_slot;
  logic [ADDR_W-1:0] ent_base_nxt;
  logic [1:0]        cap_idx;
  logic [31:0]       ras_ext;
  logic [HALF_W-1:0] len_ext;
  logic [HALF_W:0]   rec_addr;

  // Free space between the directory end and the record area.
  assign space_left = (ras_r >= dir_end_r) ? (ras_r - dir_end_r) : '0;
  assign rec_start  = ras_r - PTR_W'(len_r);
  assign sel_slot   = (op_r == OP_INSERT) ? slot_total_r : CNT_W'(slot_r);
  assign ent_base_nxt = ADDR_W'(HEADER_BYTES) +
                        ADDR_W'(32'(sel_slot) * SLOT_ENTRY_BYTES);
  assign cap_idx  = cnt_r - 2'd1;
  assign ras_ext  = 32'(ras_r);
  assign len_ext  = HALF_W'(len_r);
  assign rec_addr = {1'b0, off_r} + (HALF_W + 1)'(idx_r);

  // Status towards the controller.
  always_comb begin
    stat.op        = op_r;
    stat.fits      = CMP_W'(space_left) >= (CMP_W'(len_r) + CMP_W'(SLOT_ENTRY_BYTES));
    stat.pend_zero = (pend_r == '0);
    stat.slot_bad  = (CNT_W'(slot_r) >= slot_total_r);
    stat.idx_bad   = (HALF_W'(idx_r) >= rlen_r);
    stat.cnt_zero  = (cnt_r == 2'd0);
    stat.cnt_last  = (cnt_r == 2'd3);
    stat.out_free  = !out_valid_r || out_ready;
  end

  // Memory port selection.
  always_comb begin
    ram_en    = cmd.byte_wr || cmd.ent_wr || cmd.ent_rd || cmd.rec_rd;
    ram_we    = cmd.byte_wr || cmd.ent_wr;
    ram_addr  = ent_base_r + ADDR_W'(cnt_r);
    ram_wdata = data_r;
    if (cmd.byte_wr) begin
      ram_addr = fill_r[ADDR_W-1:0];
    end else if (cmd.rec_rd) begin
      ram_addr = rec_addr[ADDR_W-1:0];
    end
    if (cmd.ent_wr) begin
      case (cnt_r)
        2'd0:    ram_wdata = ras_ext[7:0];
        2'd1:    ram_wdata = ras_ext[15:8];
        2'd2:    ram_wdata = len_ext[7:0];
        default: ram_wdata = len_ext[15:8];
      endcase
    end
  end

  sps_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (PAGE_BYTES)
  ) u_page_ram (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // Next values of the page pointers and counters.
  always_comb begin
    slot_total_nxt = slot_total_r;
    dir_end_nxt    = dir_end_r;
    ras_nxt        = ras_r;
    fill_nxt       = fill_r;
    pend_nxt       = pend_r;
    cnt_nxt        = cnt_r;
    out_valid_nxt  = out_valid_r;
    if (cmd.init) begin
      slot_total_nxt = '0;
      dir_end_nxt    = PTR_W'(HEADER_BYTES);
      ras_nxt        = PTR_W'(PAGE_BYTES);
      fill_nxt       = '0;
      pend_nxt       = '0;
    end else if (cmd.ins_commit) begin
      slot_total_nxt = slot_total_r + CNT_W'(1);
      dir_end_nxt    = dir_end_r + PTR_W'(SLOT_ENTRY_BYTES);
      ras_nxt        = rec_start;
      fill_nxt       = rec_start;
      pend_nxt       = PEND_W'(len_r);
    end else if (cmd.byte_wr) begin
      fill_nxt = fill_r + PTR_W'(1);
      pend_nxt = pend_r - PEND_W'(1);
    end
    if (cmd.cnt_clr) begin
      cnt_nxt = '0;
    end else if (cmd.cnt_inc) begin
      cnt_nxt = cnt_r + 2'd1;
    end
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_total_r <= '0;
      dir_end_r    <= '0;
      ras_r        <= '0;
      fill_r       <= '0;
      pend_r       <= '0;
      cnt_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      slot_total_r <= slot_total_nxt;
      dir_end_r    <= dir_end_nxt;
      ras_r        <= ras_nxt;
      fill_r       <= fill_nxt;
      pend_r       <= pend_nxt;
      cnt_r        <= cnt_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Item latch, entry capture and result fields.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r           <= in_operation;
      len_r          <= in_record_length;
      data_r         <= in_data_byte;
      slot_r         <= in_slot_number;
      idx_r          <= in_byte_index;
      res_status_r   <= ST_OK;
      res_assigned_r <= '0;
      res_rdata_r    <= '0;
      res_slen_r     <= '0;
      res_done_r     <= 1'b0;
    end
    if (cmd.ent_ld) begin
      ent_base_r <= ent_base_nxt;
    end
    if (cmd.set_status) begin
      res_status_r <= cmd.status;
    end
    if (cmd.ins_commit) begin
      res_assigned_r <= slot_total_r[SLOT_W-1:0];
      res_slen_r     <= len_r;
    end
    if (cmd.byte_wr) begin
      res_done_r <= (pend_r == PEND_W'(1));
    end
    if (cmd.cap_ent) begin
      case (cap_idx)
        2'd0:    off_r[7:0]   <= ram_rdata;
        2'd1:    off_r[15:8]  <= ram_rdata;
        2'd2:    rlen_r[7:0]  <= ram_rdata;
        default: rlen_r[15:8] <= ram_rdata;
      endcase
    end
    if (cmd.slen_ld) begin
      res_slen_r <= rlen_r[LEN_W-1:0];
    end
    if (cmd.cap_rec) begin
      res_rdata_r <= ram_rdata;
    end
  end

  // Output register payload, loaded when the item finishes.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r   <= res_status_r;
      out_assigned_r <= res_assigned_r;
      out_rdata_r    <= res_rdata_r;
      out_slen_r     <= res_slen_r;
      out_done_r     <= res_done_r;
      out_free_r     <= LEN_W'(space_left);
      out_slots_r    <= slot_total_r[SLOT_W-1:0];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_assigned_slot = out_assigned_r;
  assign out_read_data     = out_rdata_r;
  assign out_stored_length = out_slen_r;
  assign out_insert_done   = out_done_r;
  assign out_free_bytes    = out_free_r;
  assign out_slots_used    = out_slots_r;

endmodule

FILE: rtl/core/slotted_page_store_top.sv
// Slotted page store: a byte-wide page buffer whose slot directory grows up from
// the header while record bytes grow down from the page end. One item is worked
// at a time through a single-port byte memory, so the cost per item is set by
// the number of memory accesses. Init, record byte, a rejected insert start and a
// read of a bad slot pass through the execute state to the done state; a
// successful insert start adds four slot entry writes, and a read byte adds four
// slot entry reads, a capture step, a length check and the record byte read; a
// bad index ends after the length check. The result is loaded into the output
// register as the controller leaves its done state for idle; a stalled result
// holds the following item back only when it is ready to be handed over. The next
// item is taken while the previous result still waits in the output register. An
// init does not clear the page memory: slot entries are always written before
// they are read, but a record byte may be read before it has been written.
// Results report free space and slot count after the item.
// Depends on sps_pkg, sps_ctrl, sps_dp and sps_ram.
module slotted_page_store_top
  import sps_pkg::*;
#(
  parameter int PAGE_BYTES   = PAGE_BYTES_DEF,
  parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // record_length[11:0], data_byte[19:12], slot_number[29:20], byte_index[41:30]
  input  logic [47:0] in_tdata,
  // operation[1:0]
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // assigned_slot[9:0], read_data[17:10], stored_length[29:18],
  // free_bytes[41:30], slots_used[51:42]
  output logic [55:0] out_tdata,
  // status[2:0]
  output logic [2:0]  out_tuser,
  // insert_done
  output logic        out_tlast
);

  cmd_t cmd;
  stat_t stat;

  logic [STATUS_W-1:0] res_status;
  logic [SLOT_W-1:0]   res_assigned;
  logic [BYTE_W-1:0]   res_rdata;
  logic [LEN_W-1:0]    res_slen;
  logic                res_done;
  logic [LEN_W-1:0]    res_free;
  logic [SLOT_W-1:0]   res_slots;

  sps_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sps_dp #(
    .PAGE_BYTES   (PAGE_BYTES),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_operation      (in_tuser),
    .in_record_length  (in_tdata[11:0]),
    .in_data_byte      (in_tdata[19:12]),
    .in_slot_number    (in_tdata[29:20]),
    .in_byte_index     (in_tdata[41:30]),
    .out_ready         (out_tready),
    .out_valid         (out_tvalid),
    .out_status        (res_status),
    .out_assigned_slot (res_assigned),
    .out_read_data     (res_rdata),
    .out_stored_length (res_slen),
    .out_insert_done   (res_done),
    .out_free_bytes    (res_free),
    .out_slots_used    (res_slots)
  );

  // Pack the result item.
  assign out_tdata = {4'b0, res_slots, res_free, res_slen, res_rdata, res_assigned};
  assign out_tuser = res_status;
  assign out_tlast = res_done;

  // Items are worked one at a time: no acceptance right after another.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("item accepted while the previous one is still in work");

  // Only a written record byte can close a record, and that always succeeds.
  a_done_is_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> (out_tuser == ST_OK))
    else $error("insert done reported with a failing status");

  // A result always carries one of the defined status codes.
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == ST_OK || out_tuser == ST_NO_SPACE ||
                    out_tuser == ST_BAD_SLOT || out_tuser == ST_BAD_IDX ||
                    out_tuser == ST_NO_OPEN))
    else $error("result status outside the defined codes");

endmodule

FILE: tb/sv/slotted_page_store_top_tb.sv
// Self-checking testbench for the slotted page store top level.
// Drives page operations as items on the input stream and checks every result against
// a page predictor or a fixed row. Depends on sps_pkg and slotted_page_store_top.
module slotted_page_store_top_tb;
  import sps_pkg::*;

  localparam int PAGE         = PAGE_BYTES_DEF;
  localparam int HDR          = HEADER_BYTES_DEF;
  localparam int RANDOM_ITEMS = 530;
  localparam int IDLE_LIMIT   = 4000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [LEN_W-1:0]  len;
    logic [BYTE_W-1:0] data;
    logic [SLOT_W-1:0] slot;
    logic [IDX_W-1:0]  idx;
  } page_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [BYTE_W-1:0]   rdata;
    logic [LEN_W-1:0]    slen;
    logic                done;
    logic [LEN_W-1:0]    free;
    logic [SLOT_W-1:0]   used;
  } page_result_t;

  // A planned item; aimed reads pick a live slot and index when they are driven.
  typedef struct packed {
    bit         aim;
    page_item_t it;
  } plan_t;

  typedef struct packed {
    bit           fixed;
    page_item_t   it;
    page_result_t res;
  } table_row_t;

  typedef struct packed {
    bit           on;
    page_result_t res;
  } fixed_exp_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;

  always #5 clk = ~clk;

  slotted_page_store_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // Predicted page contents and pointers.
  logic [7:0]  page_byte    [PAGE];
  bit          page_written [PAGE];
  logic [10:0] slot_cnt;
  logic [12:0] dir_end;
  logic [12:0] area_start;
  logic [12:0] fill_ptr;
  logic [12:0] pend_cnt;

  page_result_t expected_q [$];
  fixed_exp_t   fixed_q    [$];
  plan_t        plan_q     [$];
  table_row_t   dir_rows   [$];

  int errors      = 0;
  int idle_cycles = 0;
  int burst_left  = 0;
  int rx_left     = 0;
  int rx_mode     = 0;

  function automatic logic [12:0] page_free();
    return (area_start >= dir_end) ? area_start - dir_end : 13'd0;
  endfunction

  function automatic logic [7:0] page_get(input logic [12:0] addr);
    return (addr < 13'(PAGE)) ? page_byte[addr[11:0]] : 8'd0;
  endfunction

  task automatic page_put(input logic [12:0] addr, input logic [7:0] v);
    if (addr < 13'(PAGE)) begin
      page_byte[addr[11:0]]    = v;
      page_written[addr[11:0]] = 1'b1;
    end
  endtask

  // Decode a slot entry: record offset then record length, low byte first.
  task automatic entry_of(input logic [SLOT_W-1:0] slot, output logic [15:0] off,
                          output logic [15:0] rlen);
    logic [12:0] ea;
    ea   = 13'(HDR) + {1'b0, slot, 2'b00};
    off  = {page_get(ea + 13'd1), page_get(ea)};
    rlen = {page_get(ea + 13'd3), page_get(ea + 13'd2)};
  endtask

  task automatic page_clear_all();
    for (int a = 0; a < PAGE; a++) begin
      page_byte[a]    = 8'd0;
      page_written[a] = 1'b0;
    end
  endtask

  // Apply one item to the predicted page and work out its result.
  task automatic page_apply(input page_item_t it, output page_result_t r);
    logic [12:0] start;
    logic [12:0] ea;
    logic [12:0] fr;
    logic [15:0] off;
    logic [15:0] rlen;
    r = '0;
    r.status = ST_OK;
    case (it.op)
      OP_INIT: begin
        page_clear_all();
        slot_cnt   = '0;
        dir_end    = 13'(HDR);
        area_start = 13'(PAGE);
        fill_ptr   = '0;
        pend_cnt   = '0;
      end
      OP_INSERT: begin
        if ({1'b0, page_free()} < {2'b00, it.len} + 14'(SLOT_ENTRY_BYTES)) begin
          r.status = ST_NO_SPACE;
        end else begin
          start = area_start - {1'b0, it.len};
          ea    = 13'(HDR) + {slot_cnt, 2'b00};
          page_put(ea, start[7:0]);
          page_put(ea + 13'd1, {3'b000, start[12:8]});
          page_put(ea + 13'd2, it.len[7:0]);
          page_put(ea + 13'd3, {4'b0000, it.len[11:8]});
          r.slot     = slot_cnt[SLOT_W-1:0];
          r.slen     = it.len;
          slot_cnt   = slot_cnt + 11'd1;
          dir_end    = dir_end + 13'(SLOT_ENTRY_BYTES);
          area_start = start;
          fill_ptr   = start;
          pend_cnt   = {1'b0, it.len};
        end
      end
      OP_RECBYTE: begin
        if (pend_cnt == '0) begin
          r.status = ST_NO_OPEN;
        end else begin
          page_put(fill_ptr, it.data);
          fill_ptr = fill_ptr + 13'd1;
          pend_cnt = pend_cnt - 13'd1;
          r.done   = (pend_cnt == '0);
        end
      end
      default: begin
        if ({1'b0, it.slot} >= slot_cnt) begin
          r.status = ST_BAD_SLOT;
        end else begin
          entry_of(it.slot, off, rlen);
          r.slen = rlen[LEN_W-1:0];
          if ({4'b0000, it.idx} >= rlen) r.status = ST_BAD_IDX;
          else r.rdata = page_get(13'(off + {4'b0000, it.idx}));
        end
      end
    endcase
    fr     = page_free();
    r.free = fr[LEN_W-1:0];
    r.used = slot_cnt[SLOT_W-1:0];
  endtask

  // Aimed reads pick a live slot; any read that would land on a record byte never
  // written is turned into a bad index read instead.
  task automatic steer_read(inout page_item_t it, input bit aim);
    logic [15:0] off;
    logic [15:0] rlen;
    if (it.op == OP_READ) begin
      if (aim && slot_cnt != '0) begin
        it.slot = SLOT_W'($urandom_range(0, int'(slot_cnt) - 1));
        entry_of(it.slot, off, rlen);
        if (rlen != '0) it.idx = IDX_W'($urandom_range(0, int'(rlen) - 1));
      end
      if ({1'b0, it.slot} < slot_cnt) begin
        entry_of(it.slot, off, rlen);
        if ({4'b0000, it.idx} < rlen && !page_written[12'(off + {4'b0000, it.idx})])
          it.idx = rlen[IDX_W-1:0];
      end
    end
  endtask

  function automatic page_item_t mk_item(input logic [OP_W-1:0] op, input int unsigned len,
                                         input int unsigned data, input int unsigned slot,
                                         input int unsigned idx);
    page_item_t r;
    r.op   = op;
    r.len  = LEN_W'(len);
    r.data = BYTE_W'(data);
    r.slot = SLOT_W'(slot);
    r.idx  = IDX_W'(idx);
    return r;
  endfunction

  function automatic page_result_t mk_res(input logic [STATUS_W-1:0] status,
                                          input int unsigned slot, input int unsigned slen,
                                          input int unsigned free, input int unsigned used);
    page_result_t r;
    r        = '0;
    r.status = status;
    r.slot   = SLOT_W'(slot);
    r.slen   = LEN_W'(slen);
    r.free   = LEN_W'(free);
    r.used   = SLOT_W'(used);
    return r;
  endfunction

  function automatic page_item_t rand_item();
    page_item_t  r;
    logic [31:0] a;
    logic [31:0] b;
    a      = $urandom;
    b      = $urandom;
    r.op   = ($urandom_range(0, 7) == 0) ? OP_INIT : OP_W'($urandom_range(1, 3));
    r.len  = a[11:0];
    r.data = a[19:12];
    r.slot = a[29:20];
    r.idx  = b[11:0];
    return r;
  endfunction

  task automatic plan_push(input page_item_t it, input bit aim);
    plan_t p;
    p.aim = aim;
    p.it  = it;
    plan_q.push_back(p);
  endtask

  // Plan the next stretch of random stimulus: half of the time a whole insert followed by reads.
  task automatic plan_sequence();
    int unsigned pick;
    int unsigned n;
    page_item_t  it;
    pick = $urandom_range(0, 99);
    it   = rand_item();
    if (pick < 6) begin
      it.op = OP_INIT;
      plan_push(it, 1'b0);
    end else if (pick < 56) begin
      // A complete record: insert, every byte, then reads.
      it.op = OP_INSERT;
      n = $urandom_range(0, 9);
      if (n == 0) it.len = '0;
      else if (n < 8) it.len = LEN_W'($urandom_range(1, 12));
      else it.len = LEN_W'($urandom_range(13, 60));
      plan_push(it, 1'b0);
      for (int k = 0; k < int'(it.len); k++) begin
        it = rand_item();
        it.op = OP_RECBYTE;
        plan_push(it, 1'b0);
      end
      n = $urandom_range(1, 3);
      for (int k = 0; k < int'(n); k++) begin
        it = rand_item();
        it.op = OP_READ;
        plan_push(it, 1'b1);
      end
    end else if (pick < 64) begin
      // A large record that the next insert abandons, which eats the free space.
      it.op = OP_INSERT;
      if ($urandom_range(0, 2) != 0) it.len = LEN_W'($urandom_range(300, 2000));
      plan_push(it, 1'b0);
      n = $urandom_range(0, 3);
      for (int k = 0; k < int'(n); k++) begin
        it = rand_item();
        it.op = OP_RECBYTE;
        plan_push(it, 1'b0);
      end
    end else if (pick < 76) begin
      n = $urandom_range(2, 5);
      for (int k = 0; k < int'(n); k++) begin
        it = rand_item();
        it.op = OP_READ;
        plan_push(it, 1'b1);
      end
    end else if (pick < 90) begin
      n = $urandom_range(1, 4);
      for (int k = 0; k < int'(n); k++) begin
        plan_push(rand_item(), 1'b0);
      end
    end else begin
      // Broken sequence: stray bytes, a read of a random slot, an insert of any length.
      n = $urandom_range(1, 3);
      for (int k = 0; k < int'(n); k++) begin
        it = rand_item();
        it.op = OP_RECBYTE;
        plan_push(it, 1'b0);
      end
      it = rand_item();
      it.op = OP_READ;
      plan_push(it, 1'b0);
      it = rand_item();
      it.op = OP_INSERT;
      plan_push(it, 1'b0);
    end
  endtask

  // Offer one item in bursts with random gaps; called and returning at a falling edge.
  task automatic drive_item(input page_item_t item, input bit aim, input bit fixed,
                            input page_result_t fres);
    int unsigned gap;
    page_item_t  it;
    fixed_exp_t  fx;
    it = item;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    burst_left--;
    steer_read(it, aim);
    fx.on  = fixed;
    fx.res = fres;
    fixed_q.push_back(fx);
    in_tvalid <= 1'b1;
    in_tdata  <= {6'b0, it.idx, it.slot, it.data, it.len};
    in_tuser  <= it.op;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Receiver stalls follow phases of always ready, coin toss and mostly stalled.
  always @(negedge clk) begin
    if (rst_n) begin
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 2);
        rx_left = $urandom_range(5, 40);
      end
      rx_left--;
      case (rx_mode)
        0:       out_tready <= 1'b1;
        1:       out_tready <= 1'($urandom_range(0, 1));
        default: out_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Check each result against the oldest expectation, then predict each accepted item.
  always @(posedge clk) begin : monitor
    page_result_t got;
    page_result_t want;
    page_result_t pred;
    page_item_t   it;
    fixed_exp_t   fx;
    bit           moved;
    if (rst_n) begin
      moved = 1'b0;
      if (out_tvalid && out_tready) begin
        moved      = 1'b1;
        got.status = out_tuser;
        got.slot   = out_tdata[9:0];
        got.rdata  = out_tdata[17:10];
        got.slen   = out_tdata[29:18];
        got.free   = out_tdata[41:30];
        got.used   = out_tdata[51:42];
        got.done   = out_tlast;
        if (expected_q.size() == 0) begin
          errors++;
          $display("%0t: result with nothing expected, status %0d", $time, got.status);
        end else begin
          want = expected_q.pop_front();
          check_field("status", 16'(want.status), 16'(got.status));
          check_field("assigned_slot", 16'(want.slot), 16'(got.slot));
          check_field("read_data", 16'(want.rdata), 16'(got.rdata));
          check_field("stored_length", 16'(want.slen), 16'(got.slen));
          check_field("insert_done", 16'(want.done), 16'(got.done));
          check_field("free_bytes", 16'(want.free), 16'(got.free));
          check_field("slots_used", 16'(want.used), 16'(got.used));
        end
      end
      if (in_tvalid && in_tready) begin
        moved   = 1'b1;
        it.op   = in_tuser;
        it.len  = in_tdata[11:0];
        it.data = in_tdata[19:12];
        it.slot = in_tdata[29:20];
        it.idx  = in_tdata[41:30];
        page_apply(it, pred);
        fx = fixed_q.pop_front();
        expected_q.push_back(fx.on ? fx.res : pred);
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
    end
  end

  // Watchdog: give up when nothing moves on either side for too long.
  initial begin : watchdog
    wait (rst_n);
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("slotted_page_store_top regression: fail");
    $finish;
  end

  initial begin : stimulus
    int         sent;
    plan_t      p;
    table_row_t row;
    // State before the first init: both pointers zero.
    page_clear_all();
    slot_cnt   = '0;
    dir_end    = '0;
    area_start = '0;
    fill_ptr   = '0;
    pend_cnt   = '0;

    // Directed rows: before init, a page filled in one go, an empty record, abandoning.
    dir_rows.push_back('{1'b1, mk_item(OP_READ, 0, 0, 0, 0), mk_res(ST_BAD_SLOT, 0, 0, 0, 0)});
    dir_rows.push_back('{1'b1, mk_item(OP_INSERT, 0, 0, 0, 0),
                         mk_res(ST_NO_SPACE, 0, 0, 0, 0)});
    dir_rows.push_back('{1'b1, mk_item(OP_RECBYTE, 0, 255, 0, 0),
                         mk_res(ST_NO_OPEN, 0, 0, 0, 0)});
    dir_rows.push_back('{1'b1, mk_item(OP_INIT, 0, 0, 0, 0), mk_res(ST_OK, 0, 0, 4080, 0)});
    dir_rows.push_back('{1'b1, mk_item(OP_INSERT, 4077, 0, 0, 0),
                         mk_res(ST_NO_SPACE, 0, 0, 4080, 0)});
    dir_rows.push_back('{1'b1, mk_item(OP_INSERT, 4076, 0, 0, 0),
                         mk_res(ST_OK, 0, 4076, 0, 1)});
    dir_rows.push_back('{1'b1, mk_item(OP_READ, 0, 0, 0, 4076),
                         mk_res(ST_BAD_IDX, 0, 4076, 0, 1)});
    dir_rows.push_back('{1'b1, mk_item(OP_READ, 0, 0, 1023, 4095),
                         mk_res(ST_BAD_SLOT, 0, 0, 0, 1)});
    dir_rows.push_back('{1'b1, mk_item(OP_INSERT, 4095, 0, 0, 0),
                         mk_res(ST_NO_SPACE, 0, 0, 0, 1)});
    dir_rows.push_back('{1'b1, mk_item(OP_INIT, 0, 0, 0, 0), mk_res(ST_OK, 0, 0, 4080, 0)});
    dir_rows.push_back('{1'b1, mk_item(OP_INSERT, 0, 0, 0, 0), mk_res(ST_OK, 0, 0, 4076, 1)});
    dir_rows.push_back('{1'b1, mk_item(OP_RECBYTE, 0, 165, 0, 0),
                         mk_res(ST_NO_OPEN, 0, 0, 4076, 1)});
    dir_rows.push_back('{1'b1, mk_item(OP_READ, 0, 0, 0, 0), mk_res(ST_BAD_IDX, 0, 0, 4076, 1)});
    dir_rows.push_back('{1'b0, mk_item(OP_INSERT, 3, 0, 0, 0), '0});
    dir_rows.push_back('{1'b0, mk_item(OP_RECBYTE, 0, 0, 0, 0), '0});
    dir_rows.push_back('{1'b0, mk_item(OP_RECBYTE, 0, 255, 0, 0), '0});
    dir_rows.push_back('{1'b0, mk_item(OP_RECBYTE, 0, 90, 0, 0), '0});
    dir_rows.push_back('{1'b0, mk_item(OP_READ, 0, 0, 1, 0), '0});
    dir_rows.push_back('{1'b0, mk_item(OP_READ, 0, 0, 1, 2), '0});
    dir_rows.push_back('{1'b0, mk_item(OP_INSERT, 4, 0, 0, 0), '0});
    dir_rows.push_back('{1'b0, mk_item(OP_RECBYTE, 0, 60, 0, 0), '0});
    dir_rows.push_back('{1'b0, mk_item(OP_INSERT, 2, 0, 0, 0), '0});
    dir_rows.push_back('{1'b0, mk_item(OP_RECBYTE, 0, 195, 0, 0), '0});
    dir_rows.push_back('{1'b0, mk_item(OP_RECBYTE, 0, 129, 0, 0), '0});
    dir_rows.push_back('{1'b0, mk_item(OP_READ, 0, 0, 2, 0), '0});
    dir_rows.push_back('{1'b0, mk_item(OP_RECBYTE, 0, 126, 0, 0), '0});
    dir_rows.push_back('{1'b0, mk_item(OP_INSERT, 4080, 0, 0, 0), '0});

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      drive_item(row.it, 1'b0, row.fixed, row.res);
    end

    // Random part.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if (plan_q.size() == 0) plan_sequence();
      p = plan_q.pop_front();
      drive_item(p.it, p.aim, 1'b0, '0);
      sent++;
    end
    in_tvalid <= 1'b0;

    // Drain the outstanding results, then watch for stray ones.
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("slotted_page_store_top regression: pass");
    end else begin
      $display("slotted_page_store_top regression: fail");
    end
    $finish;
  end

endmodule
